FILE: src/multibeam_pointing_offset_core_assert.svh
// assertion macros for the pointing offset core
`ifndef MULTIBEAM_POINTING_OFFSET_CORE_ASSERT_SVH
`define MULTIBEAM_POINTING_OFFSET_CORE_ASSERT_SVH

// same-cycle implication
`define MBPO_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define MBPO_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/mbpo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbpo_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int CORDIC_STEPS  = 20;
  localparam int ANG_SHIFT     = 32 - FRACTION_BITS;

  localparam int AZ_W      = 25;
  localparam int ZEN_W     = 23;
  localparam int BEAM_W    = 3;
  localparam int ROT_W     = 26;
  localparam int RAD_W     = 26;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_AZ_RADIUS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ZEN_RADIUS = CFG_IDX_W'(1);

  localparam logic [RAD_W-1:0] AZ_RADIUS_RST =
    RAD_W'(((64'd32906 << FRACTION_BITS) + 64'd50) / 64'd100);
  localparam logic [RAD_W-1:0] ZEN_RADIUS_RST =
    RAD_W'(((64'd384005 << FRACTION_BITS) + 64'd500) / 64'd1000);

  localparam logic [BEAM_W-1:0] BEAM_FIRST_OUTER = BEAM_W'(1);
  localparam logic [BEAM_W-1:0] BEAM_LAST_OUTER  = BEAM_W'(6);

  // angles inside are degrees in Q32, trig values Q30
  localparam int ANG_W     = 44;
  localparam int TRIG_W    = 32;
  localparam int TRIG_FRAC = 30;

  localparam logic signed [ANG_W-1:0] DEG60     = $signed(ANG_W'(64'd60 << 32));
  localparam logic signed [ANG_W-1:0] DEG120    = $signed(ANG_W'(64'd120 << 32));
  localparam logic signed [ANG_W-1:0] QUARTER   = $signed(ANG_W'(64'd90 << 32));
  localparam logic signed [ANG_W-1:0] HALF_TURN = $signed(ANG_W'(64'd180 << 32));
  localparam logic signed [ANG_W-1:0] TURN      = $signed(ANG_W'(64'd360 << 32));
  localparam logic signed [ANG_W-1:0] TURN2     = $signed(ANG_W'(64'd720 << 32));
  localparam logic signed [ANG_W-1:0] TURN3     = $signed(ANG_W'(64'd1080 << 32));
  localparam logic signed [ANG_W-1:0] RND_HALF  = $signed(ANG_W'(64'd1 << (ANG_SHIFT - 1)));
  localparam logic [ANG_W-1:0]        AZ_FULL   = ANG_W'(64'd360 << FRACTION_BITS);

  localparam logic signed [TRIG_W-1:0] GAIN_Q30 = TRIG_W'(652032874);

  // offset = round(radius * trig / (225 * 2^(FRACTION_BITS+2)))
  localparam int P_W       = RAD_W + TRIG_W;
  localparam int DIV_SHIFT = FRACTION_BITS + 2;
  localparam logic [P_W:0] DIV_HALF = (P_W+1)'(64'd1800 << (FRACTION_BITS - 2));
  localparam int X_W     = P_W + 1 - DIV_SHIFT;
  localparam int RCP_K   = X_W + 8;
  localparam int RCP_M_W = X_W + 1;
  localparam logic [RCP_M_W-1:0] RCP_M =
    RCP_M_W'(((64'd1 << RCP_K) + 64'd224) / 64'd225);
  localparam int H_W  = (X_W + 1) / 2;
  localparam int MH_W = RCP_M_W - H_W;
  localparam int Q_W  = X_W - 7;
  localparam int NQ_W = Q_W + 1;

  // quotient of Q32 by Q30 kept to Q32, limit 360 degrees minus one step
  localparam int QQ_W      = 41;
  localparam int OVF_SHIFT = QQ_W - TRIG_FRAC;
  localparam int REM_W     = TRIG_W + 1;
  localparam logic [QQ_W-1:0] QUOT_LIMIT = QQ_W'((64'd360 << 32) - 64'd1);

  localparam int SC_LAT = CORDIC_STEPS + 3;
  localparam int DZ_LAT = 2;
  localparam int QD_LAT = QQ_W + 1;

  function automatic logic signed [ANG_W-1:0] atan_q32(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0:  r = 44'sd193273528320;
      1:  r = 44'sd114096026022;
      2:  r = 44'sd60285206653;
      3:  r = 44'sd30601712202;
      4:  r = 44'sd15360239177;
      5:  r = 44'sd7687607536;
      6:  r = 44'sd3844741810;
      7:  r = 44'sd1922488125;
      8:  r = 44'sd961258770;
      9:  r = 44'sd480631224;
      10: r = 44'sd240315841;
      11: r = 44'sd120157949;
      12: r = 44'sd60078978;
      13: r = 44'sd30039489;
      14: r = 44'sd15019745;
      15: r = 44'sd7509872;
      16: r = 44'sd3754936;
      17: r = 44'sd1877468;
      18: r = 44'sd938734;
      19: r = 44'sd469367;
      20: r = 44'sd234684;
      21: r = 44'sd117342;
      22: r = 44'sd58671;
      23: r = 44'sd29335;
      24: r = 44'sd14668;
      25: r = 44'sd7334;
      26: r = 44'sd3667;
      27: r = 44'sd1833;
      28: r = 44'sd917;
      29: r = 44'sd458;
      30: r = 44'sd229;
      31: r = 44'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [ANG_W-1:0] beam_angle(input logic [BEAM_W-1:0] b);
    logic signed [ANG_W-1:0] r;
    case (b)
      3'd1:    r = DEG120;
      3'd2:    r = HALF_TURN;
      3'd3:    r = -DEG120;
      3'd4:    r = -DEG60;
      3'd6:    r = DEG60;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/mbpo_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mbpo_in_if;
  import mbpo_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [AZ_W-1:0]         azimuth_in;
  logic [ZEN_W-1:0]        zenith_in;
  logic [BEAM_W-1:0]       beam_index;
  logic signed [ROT_W-1:0] rotation_angle;

  modport source (output valid, azimuth_in, zenith_in, beam_index, rotation_angle,
                  input ready);
  modport sink (input valid, azimuth_in, zenith_in, beam_index, rotation_angle,
                output ready);
endinterface

interface mbpo_out_if;
  import mbpo_pkg::*;
  logic             valid;
  logic             ready;
  logic [AZ_W-1:0]  azimuth_out;
  logic [ZEN_W-1:0] zenith_out;
  logic             quotient_saturated;

  modport source (output valid, azimuth_out, zenith_out, quotient_saturated,
                  input ready);
  modport sink (input valid, azimuth_out, zenith_out, quotient_saturated,
                output ready);
endinterface

`default_nettype wire

FILE: src/mbpo_sincos.sv
`timescale 1ns / 1ps
`default_nettype none

module mbpo_sincos (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [mbpo_pkg::ANG_W-1:0]   angle,
  output logic signed [mbpo_pkg::TRIG_W-1:0]  sin_val,
  output logic signed [mbpo_pkg::TRIG_W-1:0]  cos_val
);
  import mbpo_pkg::*;

  localparam logic signed [ANG_W-1:0] LIM_HI = HALF_TURN + TURN;
  localparam logic signed [ANG_W-1:0] LIM_LO = -(HALF_TURN + TURN);

  logic signed [ANG_W-1:0]  red_next;
  logic signed [ANG_W-1:0]  red;
  logic signed [ANG_W-1:0]  fold_next;
  logic                     flip_next;
  logic signed [TRIG_W-1:0] cx [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] cy [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0]  cz [CORDIC_STEPS+1];
  logic                     cflip [CORDIC_STEPS+1];

  // bring into [-180,180), valid for inputs within 900 degrees
  always_comb begin
    if (angle >= LIM_HI) begin
      red_next = angle - TURN2;
    end else if (angle >= HALF_TURN) begin
      red_next = angle - TURN;
    end else if (angle < LIM_LO) begin
      red_next = angle + TURN2;
    end else if (angle < -HALF_TURN) begin
      red_next = angle + TURN;
    end else begin
      red_next = angle;
    end
  end

  always_comb begin
    if (red > QUARTER) begin
      fold_next = HALF_TURN - red;
      flip_next = 1'b1;
    end else if (red < -QUARTER) begin
      fold_next = -HALF_TURN - red;
      flip_next = 1'b1;
    end else begin
      fold_next = red;
      flip_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red      <= red_next;
      cx[0]    <= GAIN_Q30;
      cy[0]    <= '0;
      cz[0]    <= fold_next;
      cflip[0] <= flip_next;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        cflip[i+1] <= cflip[i];
        if (!cz[i][ANG_W-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_q32(i);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_q32(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_val <= cy[CORDIC_STEPS];
      cos_val <= cflip[CORDIC_STEPS] ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
    end
  end

endmodule

`default_nettype wire

FILE: src/mbpo_div225.sv
`timescale 1ns / 1ps
`default_nettype none

module mbpo_div225 (
  input  logic                         clk,
  input  logic                         en,
  input  logic [mbpo_pkg::X_W-1:0]     x,
  output logic [mbpo_pkg::Q_W-1:0]     q
);
  import mbpo_pkg::*;

  localparam int XH_W  = X_W - H_W;
  localparam int PHH_W = XH_W + MH_W;
  localparam int PHL_W = XH_W + H_W;
  localparam int PLH_W = H_W + MH_W;
  localparam int PLL_W = H_W + H_W;
  localparam int SUM_W = X_W + RCP_M_W;
  localparam logic [MH_W-1:0] RCP_MH = RCP_M[RCP_M_W-1:H_W];
  localparam logic [H_W-1:0]  RCP_ML = RCP_M[H_W-1:0];

  logic [XH_W-1:0]  xh;
  logic [H_W-1:0]   xl;
  logic [PHH_W-1:0] pp_hh;
  logic [PHL_W-1:0] pp_hl;
  logic [PLH_W-1:0] pp_lh;
  logic [PLL_W-1:0] pp_ll;
  logic [SUM_W-1:0] sum;

  assign xh = x[X_W-1:H_W];
  assign xl = x[H_W-1:0];

  // multiply by the scaled reciprocal of 225 in four partial products
  assign sum = (SUM_W'(pp_hh) << (2 * H_W)) + (SUM_W'(pp_hl) << H_W)
             + (SUM_W'(pp_lh) << H_W) + SUM_W'(pp_ll);

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= PHH_W'(xh) * PHH_W'(RCP_MH);
      pp_hl <= PHL_W'(xh) * PHL_W'(RCP_ML);
      pp_lh <= PLH_W'(xl) * PLH_W'(RCP_MH);
      pp_ll <= PLL_W'(xl) * PLL_W'(RCP_ML);
      q     <= sum[SUM_W-1:RCP_K];
    end
  end

endmodule

`default_nettype wire

FILE: src/mbpo_qdiv.sv
`timescale 1ns / 1ps
`default_nettype none

module mbpo_qdiv (
  input  logic                          clk,
  input  logic                          en,
  input  logic [mbpo_pkg::Q_W-1:0]      un,
  input  logic [mbpo_pkg::TRIG_W-1:0]   us,
  output logic [mbpo_pkg::QQ_W-1:0]     mag,
  output logic                          ovf
);
  import mbpo_pkg::*;

  localparam int CMP_W = TRIG_W + OVF_SHIFT;

  logic [Q_W-1:0]    un_s  [QQ_W+1];
  logic [TRIG_W-1:0] us_s  [QQ_W+1];
  logic [REM_W-1:0]  r_s   [QQ_W+1];
  logic [QQ_W-1:0]   q_s   [QQ_W+1];
  logic              ovf_s [QQ_W+1];
  logic [REM_W:0]    sh    [QQ_W];
  logic              dbit  [QQ_W];
  logic              ge    [QQ_W];

  // quotient too wide for the result when un >= us * 2^OVF_SHIFT
  always_ff @(posedge clk) begin
    if (en) begin
      un_s[0]  <= un;
      us_s[0]  <= us;
      r_s[0]   <= REM_W'(un >> OVF_SHIFT);
      q_s[0]   <= '0;
      ovf_s[0] <= CMP_W'(un) >= {us, {OVF_SHIFT{1'b0}}};
    end
  end

  for (genvar k = 0; k < QQ_W; k++) begin : g_bit
    localparam int J = QQ_W - 1 - k;
    if (J >= TRIG_FRAC) begin : g_num
      assign dbit[k] = un_s[k][J-TRIG_FRAC];
    end else begin : g_zero
      assign dbit[k] = 1'b0;
    end
    assign sh[k] = {r_s[k], dbit[k]};
    assign ge[k] = sh[k] >= (REM_W+1)'(us_s[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        un_s[k+1]  <= un_s[k];
        us_s[k+1]  <= us_s[k];
        ovf_s[k+1] <= ovf_s[k];
        q_s[k+1]   <= {q_s[k][QQ_W-2:0], ge[k]};
        r_s[k+1]   <= ge[k] ? REM_W'(sh[k] - (REM_W+1)'(us_s[k])) : REM_W'(sh[k]);
      end
    end
  end

  assign mag = q_s[QQ_W];
  assign ovf = ovf_s[QQ_W];

endmodule

`default_nettype wire

FILE: src/multibeam_pointing_offset_core.sv
`timescale 1ns / 1ps
`default_nettype none
// throughput: one word per clock, limited by the two sin/cos pipelines and the
// 42-stage quotient divider, all fully pipelined
// whole pipeline stalls together only while the output word waits
// reset: synchronous, clears all valid bits and loads the radius registers
`include "multibeam_pointing_offset_core_assert.svh"

module multibeam_pointing_offset_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mbpo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbpo_pkg::RAD_W-1:0]         cfg_data,
  mbpo_in_if.sink                            in_word,
  mbpo_out_if.source                         out_word
);
  import mbpo_pkg::*;

  typedef struct packed {
    logic [AZ_W-1:0]  az;
    logic [ZEN_W-1:0] za;
    logic             outer;
  } sb_a_t;

  typedef struct packed {
    logic [AZ_W-1:0]  az;
    logic [ZEN_W-1:0] za;
    logic             outer;
    logic             zneg;
    logic             nneg;
  } sb_p_t;

  typedef struct packed {
    logic [AZ_W-1:0]         az;
    logic signed [ANG_W-1:0] z1;
    logic signed [NQ_W-1:0]  n;
    logic                    outer;
  } sb_b_t;

  typedef struct packed {
    logic [AZ_W-1:0]         az;
    logic signed [ANG_W-1:0] z1;
    logic                    outer;
    logic                    neg;
    logic                    nzero;
  } sb_d_t;

  logic [RAD_W-1:0] az_radius;
  logic [RAD_W-1:0] zen_radius;
  logic             en;

  always_ff @(posedge clk) begin
    if (rst) begin
      az_radius  <= AZ_RADIUS_RST;
      zen_radius <= ZEN_RADIUS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_AZ_RADIUS:  az_radius  <= cfg_data;
        REG_ZEN_RADIUS: zen_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en            = !out_word.valid || out_word.ready;
  assign in_word.ready = en && !rst;

  // input register
  logic                    v0;
  logic [AZ_W-1:0]         s0_az;
  logic [ZEN_W-1:0]        s0_za;
  logic [BEAM_W-1:0]       s0_beam;
  logic signed [ROT_W-1:0] s0_rot;
  logic signed [ANG_W-1:0] pos;
  logic                    s0_outer;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_az   <= in_word.azimuth_in;
      s0_za   <= in_word.zenith_in;
      s0_beam <= in_word.beam_index;
      s0_rot  <= in_word.rotation_angle;
    end
  end

  assign pos = beam_angle(s0_beam)
             - ($signed({{(ANG_W-ROT_W){s0_rot[ROT_W-1]}}, s0_rot}) <<< ANG_SHIFT);
  assign s0_outer = (s0_beam >= BEAM_FIRST_OUTER) && (s0_beam <= BEAM_LAST_OUTER);

  // sin/cos of the rotated beam angle
  logic signed [TRIG_W-1:0] sp;
  logic signed [TRIG_W-1:0] cp;
  logic [SC_LAT-1:0]        va;
  sb_a_t                    sba [SC_LAT];

  mbpo_sincos u_sincos_beam (
    .clk     (clk),
    .en      (en),
    .angle   (pos),
    .sin_val (sp),
    .cos_val (cp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= '0;
    end else if (en) begin
      va <= {va[SC_LAT-2:0], v0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sba[0] <= '{az: s0_az, za: s0_za, outer: s0_outer};
      for (int i = 1; i < SC_LAT; i++) begin
        sba[i] <= sba[i-1];
      end
    end
  end

  // radius products
  logic [TRIG_W-1:0] sp_abs;
  logic [TRIG_W-1:0] cp_abs;
  logic              vp;
  sb_p_t             sbp;
  logic [P_W-1:0]    pz;
  logic [P_W-1:0]    pn;

  assign sp_abs = sp[TRIG_W-1] ? TRIG_W'(-sp) : TRIG_W'(sp);
  assign cp_abs = cp[TRIG_W-1] ? TRIG_W'(-cp) : TRIG_W'(cp);

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= va[SC_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pz  <= P_W'(zen_radius) * P_W'(sp_abs);
      pn  <= P_W'(az_radius) * P_W'(cp_abs);
      sbp <= '{az: sba[SC_LAT-1].az, za: sba[SC_LAT-1].za,
               outer: sba[SC_LAT-1].outer, zneg: sp[TRIG_W-1], nneg: cp[TRIG_W-1]};
    end
  end

  // round and scale before the constant divide
  logic           vx;
  sb_p_t          sbx;
  logic [X_W-1:0] xz;
  logic [X_W-1:0] xn;
  logic [P_W:0]   pz_rnd;
  logic [P_W:0]   pn_rnd;

  assign pz_rnd = (P_W+1)'(pz) + DIV_HALF;
  assign pn_rnd = (P_W+1)'(pn) + DIV_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      vx <= 1'b0;
    end else if (en) begin
      vx <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xz  <= pz_rnd[P_W:DIV_SHIFT];
      xn  <= pn_rnd[P_W:DIV_SHIFT];
      sbx <= sbp;
    end
  end

  logic [Q_W-1:0]    qz;
  logic [Q_W-1:0]    qn;
  logic [DZ_LAT-1:0] vdz;
  sb_p_t             sbdz [DZ_LAT];

  mbpo_div225 u_div_zen (
    .clk (clk),
    .en  (en),
    .x   (xz),
    .q   (qz)
  );

  mbpo_div225 u_div_az (
    .clk (clk),
    .en  (en),
    .x   (xn),
    .q   (qn)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vdz <= '0;
    end else if (en) begin
      vdz <= {vdz[DZ_LAT-2:0], vx};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbdz[0] <= sbx;
      for (int i = 1; i < DZ_LAT; i++) begin
        sbdz[i] <= sbdz[i-1];
      end
    end
  end

  // corrected zenith and signed azimuth numerator
  logic                    vz;
  logic signed [ANG_W-1:0] z1;
  logic signed [NQ_W-1:0]  n;
  logic [AZ_W-1:0]         z_az;
  logic                    z_outer;
  logic signed [ANG_W-1:0] zoff_ext;
  logic signed [ANG_W-1:0] za32;
  logic signed [NQ_W-1:0]  n_ext;
  sb_p_t                   sbz_in;

  assign sbz_in   = sbdz[DZ_LAT-1];
  assign zoff_ext = $signed({{(ANG_W-Q_W){1'b0}}, qz});
  assign n_ext    = $signed({1'b0, qn});
  assign za32     = $signed({{(ANG_W-ZEN_W-ANG_SHIFT){1'b0}}, sbz_in.za, {ANG_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      vz <= 1'b0;
    end else if (en) begin
      vz <= vdz[DZ_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_az    <= sbz_in.az;
      z_outer <= sbz_in.outer;
      if (sbz_in.outer) begin
        z1 <= sbz_in.zneg ? za32 + zoff_ext : za32 - zoff_ext;
        n  <= sbz_in.nneg ? -n_ext : n_ext;
      end else begin
        z1 <= za32;
        n  <= '0;
      end
    end
  end

  // sin of the corrected zenith
  logic signed [TRIG_W-1:0] sz;
  logic [SC_LAT-1:0]        vb;
  sb_b_t                    sbb [SC_LAT];

  mbpo_sincos u_sincos_zen (
    .clk     (clk),
    .en      (en),
    .angle   (z1),
    .sin_val (sz),
    .cos_val ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (en) begin
      vb <= {vb[SC_LAT-2:0], vz};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbb[0] <= '{az: z_az, z1: z1, n: n, outer: z_outer};
      for (int i = 1; i < SC_LAT; i++) begin
        sbb[i] <= sbb[i-1];
      end
    end
  end

  // azimuth quotient
  sb_b_t             sbb_l;
  logic [Q_W-1:0]    un;
  logic [TRIG_W-1:0] us;
  logic [QQ_W-1:0]   qd_mag;
  logic              qd_ovf;
  logic [QD_LAT-1:0] vd;
  sb_d_t             sbd [QD_LAT];

  assign sbb_l = sbb[SC_LAT-1];
  assign un    = sbb_l.n[NQ_W-1] ? Q_W'(-sbb_l.n) : Q_W'(sbb_l.n);
  assign us    = sz[TRIG_W-1] ? TRIG_W'(-sz) : TRIG_W'(sz);

  mbpo_qdiv u_qdiv (
    .clk (clk),
    .en  (en),
    .un  (un),
    .us  (us),
    .mag (qd_mag),
    .ovf (qd_ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (en) begin
      vd <= {vd[QD_LAT-2:0], vb[SC_LAT-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbd[0] <= '{az: sbb_l.az, z1: sbb_l.z1, outer: sbb_l.outer,
                  neg: sbb_l.n[NQ_W-1] ^ sz[TRIG_W-1], nzero: sbb_l.n == '0};
      for (int i = 1; i < QD_LAT; i++) begin
        sbd[i] <= sbd[i-1];
      end
    end
  end

  // apply quotient, half turn and zenith mirror
  sb_d_t                   sbd_l;
  logic                    q_sat;
  logic [QQ_W-1:0]         q_mag;
  logic signed [ANG_W-1:0] q_ext;
  logic signed [ANG_W-1:0] q_sgn;
  logic signed [ANG_W-1:0] az32;
  logic                    f1_valid;
  logic                    f1_sat;
  logic signed [ANG_W-1:0] f1_az;
  logic signed [ANG_W-1:0] f1_z;

  assign sbd_l = sbd[QD_LAT-1];
  assign q_sat = sbd_l.outer && !sbd_l.nzero && (qd_ovf || (qd_mag > QUOT_LIMIT));
  assign q_mag = q_sat ? QUOT_LIMIT : qd_mag;
  assign q_ext = $signed({{(ANG_W-QQ_W){1'b0}}, q_mag});
  assign q_sgn = (!sbd_l.outer || sbd_l.nzero) ? '0 : (sbd_l.neg ? -q_ext : q_ext);
  assign az32  = $signed({{(ANG_W-AZ_W-ANG_SHIFT){1'b0}}, sbd_l.az, {ANG_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= vd[QD_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_sat <= q_sat;
      if (sbd_l.z1 < 0) begin
        f1_az <= az32 - q_sgn + TURN;
        f1_z  <= -sbd_l.z1;
      end else begin
        f1_az <= az32 - q_sgn + HALF_TURN;
        f1_z  <= sbd_l.z1;
      end
    end
  end

  // wrap azimuth into one turn
  logic                    f2_valid;
  logic                    f2_sat;
  logic signed [ANG_W-1:0] f2_az;
  logic signed [ANG_W-1:0] f2_z;
  logic signed [ANG_W-1:0] az_wrap;

  always_comb begin
    if (f1_az < 0) begin
      az_wrap = f1_az + TURN;
    end else if (f1_az >= TURN3) begin
      az_wrap = f1_az - TURN3;
    end else if (f1_az >= TURN2) begin
      az_wrap = f1_az - TURN2;
    end else if (f1_az >= TURN) begin
      az_wrap = f1_az - TURN;
    end else begin
      az_wrap = f1_az;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (en) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_sat <= f1_sat;
      f2_az  <= az_wrap;
      f2_z   <= f1_z;
    end
  end

  // round to output format
  logic [ANG_W-1:0] az_sum;
  logic [ANG_W-1:0] z_sum;
  logic [ANG_W-1:0] az_rnd;
  logic [ANG_W-1:0] z_rnd;

  assign az_sum = ANG_W'(f2_az + RND_HALF);
  assign z_sum  = ANG_W'(f2_z + RND_HALF);
  assign az_rnd = az_sum >> ANG_SHIFT;
  assign z_rnd  = z_sum >> ANG_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_word.valid <= 1'b0;
    end else if (en) begin
      out_word.valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word.azimuth_out        <= (az_rnd == AZ_FULL) ? '0 : az_rnd[AZ_W-1:0];
      out_word.zenith_out         <= (|z_rnd[ANG_W-1:ZEN_W]) ? '1 : z_rnd[ZEN_W-1:0];
      out_word.quotient_saturated <= f2_sat;
    end
  end

  `MBPO_ASSERT_NEXT(a_stall_holds_pipe, !en, $stable(vb) && $stable(vd), "pipeline moved while stalled")
  `MBPO_ASSERT_NEXT(a_central_no_sat, en && vd[QD_LAT-1] && !sbd_l.outer, !f1_sat, "central beam flagged saturation")
  `MBPO_ASSERT_IMP(a_az_in_turn, out_word.valid, ANG_W'(out_word.azimuth_out) < AZ_FULL, "azimuth not wrapped")

endmodule

`default_nettype wire
